FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
// Depends on a clk and an active-low arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that an implication holds on every rising clock edge outside reset.
`define RBC_ASSERT_IMP(lbl, ante, cons, msg) \
	`RBC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/rbc_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the reorder buffer commit unit. No dependencies.
package rbc_pkg;

	localparam int DEPTH      = 32;
	localparam int TAG_W      = $clog2(DEPTH);
	localparam int OCC_W      = TAG_W + 1;
	localparam int FULL_LIMIT = DEPTH - 2;

	// ALU writeback codes
	localparam logic [1:0] AK_VALUE  = 2'd1;
	localparam logic [1:0] AK_BRANCH = 2'd2;

	// Decoder entry codes
	localparam logic [2:0] DK_REG    = 3'd1;
	localparam logic [2:0] DK_BRANCH = 3'd2;
	localparam logic [2:0] DK_STORE  = 3'd3;
	localparam logic [2:0] DK_EXIT   = 3'd4;

	// Result codes
	localparam logic [2:0] RK_STATUS  = 3'd0;
	localparam logic [2:0] RK_REG     = 3'd1;
	localparam logic [2:0] RK_STORE   = 3'd2;
	localparam logic [2:0] RK_BR_OK   = 3'd3;
	localparam logic [2:0] RK_MISPRED = 3'd4;
	localparam logic [2:0] RK_EXIT    = 3'd5;

	typedef struct packed {
		logic cap_in;
		logic flush;
		logic alu_rd;
		logic alu_wr;
		logic dec_wr;
		logic load_wr;
		logic emit_commit;
		logic emit_status;
	} rbc_cmd_t;

	typedef struct packed {
		logic halted;
		logic flush_pending;
		logic can_retire;
		logic head_stop;
		logic out_free;
	} rbc_sts_t;

endpackage

FILE: rtl/rbc_ctrl.sv
// Step sequencer of the reorder buffer commit unit.
// Depends on rbc_pkg for the command and status types.
module rbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rbc_pkg::rbc_sts_t sts,
	output rbc_pkg::rbc_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALU_RD,
		S_ALU_WR,
		S_DEC,
		S_LOAD,
		S_RET_RD,
		S_RET,
		S_STATUS
	} state_t;

	state_t state_q;

	// Accept a new step only between steps
	assign req_stall = (state_q != S_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.cap_in = req_valid;
			S_ALU_RD: begin
				cmd.alu_rd = 1'b1;
				cmd.flush  = sts.flush_pending && !sts.halted;
			end
			S_ALU_WR: cmd.alu_wr  = 1'b1;
			S_DEC:    cmd.dec_wr  = 1'b1;
			S_LOAD:   cmd.load_wr = 1'b1;
			S_RET_RD: ;
			S_RET:    cmd.emit_commit = sts.can_retire && sts.out_free;
			S_STATUS: cmd.emit_status = sts.out_free;
			default:  ;
		endcase
	end

	// Advance the step sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (req_valid) state_q <= S_ALU_RD;
				S_ALU_RD: begin
					if (sts.halted || sts.flush_pending) state_q <= S_STATUS;
					else state_q <= S_ALU_WR;
				end
				S_ALU_WR: state_q <= S_DEC;
				S_DEC:    state_q <= S_LOAD;
				S_LOAD:   state_q <= S_RET_RD;
				S_RET_RD: state_q <= S_RET;
				S_RET: begin
					if (!sts.can_retire) state_q <= S_STATUS;
					else if (sts.out_free) begin
						if (sts.head_stop) state_q <= S_STATUS;
						else state_q <= S_RET_RD;
					end
				end
				S_STATUS: if (sts.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/rbc_datapath.sv
// Entry storage, pointers and result register of the reorder buffer.
// Depends on rbc_pkg; driven by rbc_ctrl through command signals.
module rbc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rbc_pkg::rbc_cmd_t          cmd,
	output rbc_pkg::rbc_sts_t          sts,
	input  logic [1:0]                 alu_kind,
	input  logic [rbc_pkg::TAG_W-1:0]  alu_tag,
	input  logic [31:0]                alu_value,
	input  logic [2:0]                 dec_kind,
	input  logic [31:0]                dec_dest_or_target,
	input  logic [31:0]                dec_value,
	input  logic                       dec_ready,
	input  logic                       load_valid,
	input  logic [rbc_pkg::TAG_W-1:0]  load_tag,
	input  logic [31:0]                load_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [2:0]                 kind,
	output logic [rbc_pkg::TAG_W-1:0]  entry_tag,
	output logic [31:0]                dest_or_target,
	output logic [31:0]                commit_value,
	output logic [29:0]                predictor_index,
	output logic                       branch_taken,
	output logic                       rename_valid,
	output logic [rbc_pkg::TAG_W-1:0]  rename_tag,
	output logic [rbc_pkg::TAG_W-1:0]  tail_index,
	output logic                       full_res,
	output logic                       last
);

	localparam int TW = rbc_pkg::TAG_W;
	localparam int OW = rbc_pkg::OCC_W;

	// Captured step inputs
	logic [1:0]    alu_kind_q;
	logic [TW-1:0] alu_tag_q;
	logic [31:0]   alu_value_q;
	logic [2:0]    dec_kind_q;
	logic [31:0]   dec_dest_q;
	logic [31:0]   dec_value_q;
	logic          dec_ready_q;
	logic          load_valid_q;
	logic [TW-1:0] load_tag_q;
	logic [31:0]   load_data_q;

	// Entry storage
	logic [2:0]  kind_mem [rbc_pkg::DEPTH];
	logic [31:0] dest_mem [rbc_pkg::DEPTH];
	logic [31:0] val_mem  [rbc_pkg::DEPTH];
	logic [rbc_pkg::DEPTH-1:0] ready_q;
	logic [2:0]  kind_rd_q;
	logic [31:0] dest_rd_q;
	logic [31:0] val_rd_q;

	// Control state
	logic [TW-1:0] head_q;
	logic [TW-1:0] tail_q;
	logic [OW-1:0] occ_q;
	logic          flush_pend_q;
	logic          halted_q;
	logic          ren_v_q;
	logic [TW-1:0] ren_tag_q;
	logic          out_valid_q;

	logic          alu_hit;
	logic          dec_hit;
	logic          dec_ren;
	logic [31:0]   br_value;
	logic [TW-1:0] rd_addr;
	logic          hd_exit;
	logic          hd_mispred;
	logic [2:0]    commit_kind;

	assign alu_hit = (alu_kind_q == rbc_pkg::AK_VALUE) || (alu_kind_q == rbc_pkg::AK_BRANCH);
	assign dec_hit = (dec_kind_q == rbc_pkg::DK_REG) || (dec_kind_q == rbc_pkg::DK_BRANCH) ||
		(dec_kind_q == rbc_pkg::DK_STORE) || (dec_kind_q == rbc_pkg::DK_EXIT);
	assign dec_ren = ((dec_kind_q == rbc_pkg::DK_REG) || (dec_kind_q == rbc_pkg::DK_EXIT)) &&
		(dec_dest_q != 32'd0) && dec_hit && (occ_q != OW'(rbc_pkg::DEPTH));

	// Shift the correct-prediction bit into a branch entry
	assign br_value = {val_rd_q[30:0], (alu_value_q == {31'd0, val_rd_q[0]})};

	assign rd_addr = cmd.alu_rd ? alu_tag_q : head_q;

	// Classify the head entry
	assign hd_exit    = (kind_rd_q == rbc_pkg::DK_EXIT);
	assign hd_mispred = (kind_rd_q == rbc_pkg::DK_BRANCH) && !val_rd_q[0];
	always_comb begin
		priority if (hd_exit) commit_kind = rbc_pkg::RK_EXIT;
		else if (kind_rd_q == rbc_pkg::DK_BRANCH)
			commit_kind = val_rd_q[0] ? rbc_pkg::RK_BR_OK : rbc_pkg::RK_MISPRED;
		else if (kind_rd_q == rbc_pkg::DK_STORE) commit_kind = rbc_pkg::RK_STORE;
		else commit_kind = rbc_pkg::RK_REG;
	end

	assign sts.halted        = halted_q;
	assign sts.flush_pending = flush_pend_q;
	assign sts.can_retire    = (occ_q != '0) && ready_q[head_q];
	assign sts.head_stop     = hd_exit || hd_mispred;
	assign sts.out_free      = !out_valid_q || !res_stall;

	// Capture step inputs
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			alu_kind_q   <= alu_kind;
			alu_tag_q    <= alu_tag;
			alu_value_q  <= alu_value;
			dec_kind_q   <= dec_kind;
			dec_dest_q   <= dec_dest_or_target;
			dec_value_q  <= dec_value;
			dec_ready_q  <= dec_ready;
			load_valid_q <= load_valid;
			load_tag_q   <= load_tag;
			load_data_q  <= load_data;
		end
	end

	// Write and read the entry memories
	always_ff @(posedge clk) begin
		if (cmd.alu_wr && alu_hit)
			val_mem[alu_tag_q] <= (alu_kind_q == rbc_pkg::AK_BRANCH) ? br_value : alu_value_q;
		if (cmd.dec_wr && dec_hit && (occ_q != OW'(rbc_pkg::DEPTH))) begin
			kind_mem[tail_q] <= dec_kind_q;
			dest_mem[tail_q] <= dec_dest_q;
			val_mem[tail_q]  <= dec_value_q;
		end
		if (cmd.load_wr && load_valid_q)
			val_mem[load_tag_q] <= load_data_q;
		kind_rd_q <= kind_mem[head_q];
		dest_rd_q <= dest_mem[head_q];
		val_rd_q  <= val_mem[rd_addr];
	end

	// Hold ready bits, pointers and step flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			occ_q        <= '0;
			flush_pend_q <= 1'b0;
			halted_q     <= 1'b0;
			ren_v_q      <= 1'b0;
			ren_tag_q    <= '0;
		end else begin
			if (cmd.cap_in) begin
				ren_v_q   <= 1'b0;
				ren_tag_q <= '0;
			end
			if (cmd.flush) begin
				flush_pend_q <= 1'b0;
				head_q       <= '0;
				tail_q       <= '0;
				occ_q        <= '0;
			end
			if (cmd.alu_wr && alu_hit) ready_q[alu_tag_q] <= 1'b1;
			if (cmd.dec_wr && dec_hit && (occ_q != OW'(rbc_pkg::DEPTH))) begin
				ready_q[tail_q] <= dec_ready_q;
				tail_q          <= tail_q + 1'b1;
				occ_q           <= occ_q + 1'b1;
				ren_v_q         <= dec_ren;
				ren_tag_q       <= dec_ren ? tail_q : '0;
			end
			if (cmd.load_wr && load_valid_q) ready_q[load_tag_q] <= 1'b1;
			if (cmd.emit_commit) begin
				priority if (hd_exit) halted_q <= 1'b1;
				else if (hd_mispred) flush_pend_q <= 1'b1;
				else begin
					ready_q[head_q] <= 1'b0;
					head_q          <= head_q + 1'b1;
					occ_q           <= occ_q - 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_commit || cmd.emit_status) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_commit) begin
			kind            <= commit_kind;
			entry_tag       <= head_q;
			dest_or_target  <= dest_rd_q;
			commit_value    <= val_rd_q;
			predictor_index <= (kind_rd_q == rbc_pkg::DK_BRANCH) ? val_rd_q[31:2] : '0;
			branch_taken    <= (kind_rd_q == rbc_pkg::DK_BRANCH) && (val_rd_q[1] == val_rd_q[0]);
			rename_valid    <= 1'b0;
			rename_tag      <= '0;
			tail_index      <= '0;
			full_res        <= 1'b0;
			last            <= 1'b0;
		end else if (cmd.emit_status) begin
			kind            <= rbc_pkg::RK_STATUS;
			entry_tag       <= '0;
			dest_or_target  <= '0;
			commit_value    <= '0;
			predictor_index <= '0;
			branch_taken    <= 1'b0;
			rename_valid    <= ren_v_q;
			rename_tag      <= ren_tag_q;
			tail_index      <= tail_q;
			full_res        <= !flush_pend_q && (occ_q > OW'(rbc_pkg::FULL_LIMIT));
			last            <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;

endmodule

FILE: rtl/reorder_buffer_commit_unit.sv
// Reorder buffer commit unit: top level joining controller and datapath.
// Depends on rbc_pkg, rbc_ctrl and rbc_datapath.
//
// Each accepted transaction is one processor step: ALU writeback, decoder
// allocation at the tail, load writeback, then in-order retirement from the
// head, followed by one status result marked by last. One step at a time is
// in flight. A step runs the states ALU read, ALU write, decoder write, load
// write, head read and retire, then the status result. Each retired entry
// after which retirement goes on adds a head read of the new head from the
// registered entry memory and a retire state; an exit or a mispredicted
// branch ends retirement at once. res_stall holds results back. A flush or
// halted step skips from ALU read to status. The next transaction is
// accepted the cycle after the status result is loaded. The single write
// port of the entry memory sets the serial writeback and allocation cycles.
module reorder_buffer_commit_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 alu_kind,
	input  logic [rbc_pkg::TAG_W-1:0]  alu_tag,
	input  logic signed [31:0]         alu_value,
	input  logic [2:0]                 dec_kind,
	input  logic [31:0]                dec_dest_or_target,
	input  logic signed [31:0]         dec_value,
	input  logic                       dec_ready,
	input  logic                       load_valid,
	input  logic [rbc_pkg::TAG_W-1:0]  load_tag,
	input  logic signed [31:0]         load_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [2:0]                 kind,
	output logic [rbc_pkg::TAG_W-1:0]  entry_tag,
	output logic [31:0]                dest_or_target,
	output logic signed [31:0]         commit_value,
	output logic [29:0]                predictor_index,
	output logic                       branch_taken,
	output logic                       rename_valid,
	output logic [rbc_pkg::TAG_W-1:0]  rename_tag,
	output logic [rbc_pkg::TAG_W-1:0]  tail_index,
	output logic                       full_res,
	output logic                       last
);

	rbc_pkg::rbc_cmd_t cmd;
	rbc_pkg::rbc_sts_t sts;

	rbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rbc_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.alu_kind           (alu_kind),
		.alu_tag            (alu_tag),
		.alu_value          (alu_value),
		.dec_kind           (dec_kind),
		.dec_dest_or_target (dec_dest_or_target),
		.dec_value          (dec_value),
		.dec_ready          (dec_ready),
		.load_valid         (load_valid),
		.load_tag           (load_tag),
		.load_data          (load_data),
		.res_valid          (res_valid),
		.res_stall          (res_stall),
		.kind               (kind),
		.entry_tag          (entry_tag),
		.dest_or_target     (dest_or_target),
		.commit_value       (commit_value),
		.predictor_index    (predictor_index),
		.branch_taken       (branch_taken),
		.rename_valid       (rename_valid),
		.rename_tag         (rename_tag),
		.tail_index         (tail_index),
		.full_res           (full_res),
		.last               (last)
	);

endmodule

FILE: rtl/rbc_checker.sv
// Port-level checks for the reorder buffer commit unit, bound to its top.
// Depends on assert_macros.svh and rbc_pkg.
`include "assert_macros.svh"

module rbc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      res_valid,
	input logic                      res_stall,
	input logic [2:0]                kind,
	input logic [rbc_pkg::TAG_W-1:0] tail_index,
	input logic                      last
);

	// A held result keeps its code
	`RBC_ASSERT_IMP(a_res_hold, res_valid && res_stall, ##1 (res_valid && $stable(kind)), "result changed while stalled")
	// One step at a time: busy right after a step is taken
	`RBC_ASSERT_IMP(a_busy_after_accept, req_valid && !req_stall, ##1 req_stall, "step accepted while busy")
	// Only the status result closes a step
	`RBC_ASSERT_IMP(a_last_is_status, res_valid, (last == (kind == rbc_pkg::RK_STATUS)), "last flag wrong")
	// Commit results carry no tail
	`RBC_ASSERT_IMP(a_commit_no_tail, res_valid && !last, (tail_index == '0), "tail on commit result")

endmodule

bind reorder_buffer_commit_unit rbc_checker u_rbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.kind       (kind),
	.tail_index (tail_index),
	.last       (last)
);

FILE: tb/sv/rbc_checker.sv
// Scoreboard for the reorder buffer commit unit: predicts the results of each
// accepted step and compares them with the result channel. Depends on rbc_pkg.
module rbc_scoreboard (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic [1:0]                   alu_kind,
	input  logic [rbc_pkg::TAG_W-1:0]    alu_tag,
	input  logic signed [31:0]           alu_value,
	input  logic [2:0]                   dec_kind,
	input  logic [31:0]                  dec_dest_or_target,
	input  logic signed [31:0]           dec_value,
	input  logic                         dec_ready,
	input  logic                         load_valid,
	input  logic [rbc_pkg::TAG_W-1:0]    load_tag,
	input  logic signed [31:0]           load_data,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  logic [2:0]                   kind,
	input  logic [rbc_pkg::TAG_W-1:0]    entry_tag,
	input  logic [31:0]                  dest_or_target,
	input  logic signed [31:0]           commit_value,
	input  logic [29:0]                  predictor_index,
	input  logic                         branch_taken,
	input  logic                         rename_valid,
	input  logic [rbc_pkg::TAG_W-1:0]    rename_tag,
	input  logic [rbc_pkg::TAG_W-1:0]    tail_index,
	input  logic                         full_res,
	input  logic                         last,
	output int                           fail_count,
	output int                           commits_pending,
	output logic [rbc_pkg::DEPTH-1:0]    written_mask,
	output logic [rbc_pkg::TAG_W-1:0]    head_pos,
	output int                           fill_level
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]                kind;
		logic [rbc_pkg::TAG_W-1:0] tag;
		logic [31:0]               dest;
		logic [31:0]               val;
		logic [29:0]               pidx;
		logic                      taken;
		logic                      rv;
		logic [rbc_pkg::TAG_W-1:0] rt;
		logic [rbc_pkg::TAG_W-1:0] tail;
		logic                      full;
		logic                      last;
	} commit_t;

	commit_t                   commit_q[$];
	logic [2:0]                rob_kind[rbc_pkg::DEPTH];
	logic [31:0]               rob_dest[rbc_pkg::DEPTH];
	logic [31:0]               rob_val[rbc_pkg::DEPTH];
	logic [rbc_pkg::DEPTH-1:0] rob_ready;
	logic [rbc_pkg::DEPTH-1:0] rob_written;
	logic [rbc_pkg::TAG_W-1:0] rob_head, rob_tail;
	int                        rob_occ;
	logic                      flush_p, halt_p;
	int                        errs;

	assign fail_count = errs;

	function automatic commit_t mk(logic [2:0] k, logic [rbc_pkg::TAG_W-1:0] t,
			logic [31:0] d, logic [31:0] v, logic [29:0] p, logic tk, logic rv,
			logic [rbc_pkg::TAG_W-1:0] rt, logic [rbc_pkg::TAG_W-1:0] tl, logic fl,
			logic ls);
		commit_t c;
		c = '{k, t, d, v, p, tk, rv, rt, tl, fl, ls};
		return c;
	endfunction

	// Advance the buffer by one processor step and queue its results
	task automatic advance_step();
		logic [31:0]               v;
		logic [rbc_pkg::TAG_W-1:0] h;
		logic                      rv, tk;
		logic [rbc_pkg::TAG_W-1:0] rt;
		rv = 1'b0;
		rt = '0;
		if (halt_p) begin
			commit_q.push_back(mk(rbc_pkg::RK_STATUS, 0, 0, 0, 0, 0, 0, 0, rob_tail,
				rob_occ > rbc_pkg::FULL_LIMIT, 1));
			return;
		end
		if (flush_p) begin
			flush_p = 1'b0;
			rob_head = '0;
			rob_tail = '0;
			rob_occ = 0;
			commit_q.push_back(mk(rbc_pkg::RK_STATUS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		// ALU writeback
		if (alu_kind == rbc_pkg::AK_VALUE || alu_kind == rbc_pkg::AK_BRANCH) begin
			if (alu_kind == rbc_pkg::AK_BRANCH) begin
				v = rob_val[alu_tag];
				rob_val[alu_tag] = {v[30:0], (alu_value == {31'd0, v[0]})};
			end else begin
				rob_val[alu_tag] = alu_value;
			end
			rob_ready[alu_tag] = 1'b1;
			rob_written[alu_tag] = 1'b1;
		end
		// allocate at the tail
		if (dec_kind >= rbc_pkg::DK_REG && dec_kind <= rbc_pkg::DK_EXIT &&
				rob_occ < rbc_pkg::DEPTH) begin
			if ((dec_kind == rbc_pkg::DK_REG || dec_kind == rbc_pkg::DK_EXIT) &&
					dec_dest_or_target != 0) begin
				rv = 1'b1;
				rt = rob_tail;
			end
			rob_kind[rob_tail] = dec_kind;
			rob_dest[rob_tail] = dec_dest_or_target;
			rob_val[rob_tail] = dec_value;
			rob_ready[rob_tail] = dec_ready;
			rob_written[rob_tail] = 1'b1;
			rob_tail = rob_tail + 1'b1;
			rob_occ++;
		end
		// load writeback
		if (load_valid) begin
			rob_val[load_tag] = load_data;
			rob_ready[load_tag] = 1'b1;
			rob_written[load_tag] = 1'b1;
		end
		// retire in order
		while (rob_occ != 0 && rob_ready[rob_head]) begin
			h = rob_head;
			v = rob_val[h];
			if (rob_kind[h] == rbc_pkg::DK_EXIT) begin
				commit_q.push_back(mk(rbc_pkg::RK_EXIT, h, rob_dest[h], v, 0, 0, 0, 0,
					0, 0, 0));
				halt_p = 1'b1;
				break;
			end
			if (rob_kind[h] == rbc_pkg::DK_BRANCH) begin
				tk = (v[1] == v[0]);
				if (!v[0]) begin
					commit_q.push_back(mk(rbc_pkg::RK_MISPRED, h, rob_dest[h], v, v[31:2],
						tk, 0, 0, 0, 0, 0));
					flush_p = 1'b1;
					break;
				end
				commit_q.push_back(mk(rbc_pkg::RK_BR_OK, h, rob_dest[h], v, v[31:2], tk,
					0, 0, 0, 0, 0));
			end else begin
				commit_q.push_back(mk(rob_kind[h] == rbc_pkg::DK_STORE ?
					rbc_pkg::RK_STORE : rbc_pkg::RK_REG, h,
					rob_dest[h], v, 0, 0, 0, 0, 0, 0, 0));
			end
			rob_ready[h] = 1'b0;
			rob_head = rob_head + 1'b1;
			rob_occ--;
		end
		commit_q.push_back(mk(rbc_pkg::RK_STATUS, 0, 0, 0, 0, 0, rv, rt, rob_tail,
			!flush_p && rob_occ > rbc_pkg::FULL_LIMIT, 1));
	endtask

	task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			errs++;
		end
	endtask

	// Compare results, then predict newly accepted steps
	always @(posedge clk or negedge arst_n) begin
		commit_t e;
		if (!arst_n) begin
			commit_q.delete();
			rob_ready = '0;
			rob_written = '0;
			rob_head = '0;
			rob_tail = '0;
			rob_occ = 0;
			flush_p = 1'b0;
			halt_p = 1'b0;
			errs = 0;
			for (int i = 0; i < rbc_pkg::DEPTH; i++) begin
				rob_kind[i] = '0;
				rob_dest[i] = '0;
				rob_val[i] = '0;
			end
		end else begin
			if (res_valid && !res_stall) begin
				if (commit_q.size() == 0) begin
					$error("unexpected result transaction, kind %0d", kind);
					errs++;
				end else begin
					e = commit_q.pop_front();
					cmp("kind", e.kind, kind);
					cmp("entry_tag", e.tag, entry_tag);
					cmp("dest_or_target", e.dest, dest_or_target);
					cmp("commit_value", e.val, commit_value);
					cmp("predictor_index", e.pidx, predictor_index);
					cmp("branch_taken", e.taken, branch_taken);
					cmp("rename_valid", e.rv, rename_valid);
					cmp("rename_tag", e.rt, rename_tag);
					cmp("tail_index", e.tail, tail_index);
					cmp("full_res", e.full, full_res);
					cmp("last", e.last, last);
				end
			end
			if (req_valid && !req_stall)
				advance_step();
		end
		commits_pending <= commit_q.size();
		written_mask <= rob_written;
		head_pos <= rob_head;
		fill_level <= rob_occ;
	end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the reorder buffer commit unit: clock, reset, step
// stimulus and verdict. Depends on rbc_pkg, rbc_scoreboard and the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [1:0]  ak;
		logic [4:0]  atag;
		logic [31:0] aval;
		logic [2:0]  dk;
		logic [31:0] ddest;
		logic [31:0] dval;
		logic        drdy;
		logic        lv;
		logic [4:0]  ltag;
		logic [31:0] lval;
	} step_t;

	logic clk, arst_n;
	logic req_valid, req_stall, res_valid, res_stall;
	logic [1:0] alu_kind;
	logic [rbc_pkg::TAG_W-1:0] alu_tag, load_tag, entry_tag, rename_tag, tail_index;
	logic signed [31:0] alu_value, dec_value, load_data, commit_value;
	logic [2:0] dec_kind, kind;
	logic [31:0] dec_dest_or_target, dest_or_target;
	logic dec_ready, load_valid, branch_taken, rename_valid, full_res, last;
	logic [29:0] predictor_index;
	int fail_count, commits_pending, fill_level, idle_cycles;
	logic [rbc_pkg::DEPTH-1:0] written_mask;
	logic [rbc_pkg::TAG_W-1:0] head_pos;
	int send_idle_pct, recv_stall_pct, wb_pct;

	reorder_buffer_commit_unit dut (.*);
	rbc_scoreboard chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall results at the current receiver rate
	always @(posedge clk)
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// Stop when no transaction moves for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(step_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		alu_kind <= s.ak;
		alu_tag <= s.atag;
		alu_value <= s.aval;
		dec_kind <= s.dk;
		dec_dest_or_target <= s.ddest;
		dec_value <= s.dval;
		dec_ready <= s.drdy;
		load_valid <= s.lv;
		load_tag <= s.ltag;
		load_data <= s.lval;
		do @(posedge clk); while (req_stall);
	endtask

	// Hold until every result is back so the checker state is current
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (commits_pending != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic step_t mk(logic [1:0] ak, logic [4:0] at, logic [31:0] av,
			logic [2:0] dk, logic [31:0] dd, logic [31:0] dv, logic dr,
			logic lv, logic [4:0] lt, logic [31:0] lval);
		step_t s;
		s = '{ak, at, av, dk, dd, dv, dr, lv, lt, lval};
		return s;
	endfunction

	// Pick a tag, mostly one that is in flight
	function automatic logic [4:0] pick_tag();
		if (fill_level > 0 && $urandom_range(0, 9) < 8)
			return head_pos + 5'($urandom_range(0, fill_level - 1));
		return 5'($urandom);
	endfunction

	function automatic step_t rand_step();
		step_t s;
		int r;
		s = mk(0, 0, $urandom, 0, $urandom, $urandom, $urandom_range(0, 9) < 4,
			0, 0, $urandom);
		if ($urandom_range(0, 99) < wb_pct) begin
			r = $urandom_range(0, 99);
			s.ak = r < 40 ? rbc_pkg::AK_VALUE : r < 85 ? rbc_pkg::AK_BRANCH : 2'd3;
			s.atag = pick_tag();
			// a branch outcome needs an entry that holds a value
			if (s.ak == rbc_pkg::AK_BRANCH && !written_mask[s.atag])
				s.ak = rbc_pkg::AK_VALUE;
			if (s.ak == rbc_pkg::AK_BRANCH && $urandom_range(0, 9) < 8)
				s.aval = $urandom_range(0, 1);
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			s.dk = 3'($urandom_range(rbc_pkg::DK_REG, rbc_pkg::DK_STORE));
			if (s.dk == rbc_pkg::DK_BRANCH && $urandom_range(0, 9) < 8)
				s.dval[0] = 1'b1;
		end else if (r < 76) begin
			s.dk = 3'($urandom_range(5, 7));
		end
		if ($urandom_range(0, 4) == 0)
			s.ddest = 0;
		if ($urandom_range(0, 99) < wb_pct) begin
			s.lv = 1'b1;
			s.ltag = pick_tag();
		end
		return s;
	endfunction

	initial begin
		int mode;
		step_t s;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wb_pct = 40;
		arst_n = 1'b0;
		req_valid = 1'b0;
		alu_kind = '0;
		alu_tag = '0;
		alu_value = '0;
		dec_kind = '0;
		dec_dest_or_target = '0;
		dec_value = '0;
		dec_ready = 1'b0;
		load_valid = 1'b0;
		load_tag = '0;
		load_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register writer ready at allocation, no rename
		send(mk(0, 0, 0, rbc_pkg::DK_REG, 32'h0, 32'h7FFF_FFFF, 1, 0, 0, 0));
		// register writer completed by an ALU value
		send(mk(0, 0, 0, rbc_pkg::DK_REG, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0));
		send(mk(rbc_pkg::AK_VALUE, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
		// store completed by a load in the same step
		send(mk(0, 0, 0, rbc_pkg::DK_STORE, 32'h1234_5678, 0, 0, 1, 2, 32'hFFFF_FFFF));
		// correctly predicted branch
		send(mk(0, 0, 0, rbc_pkg::DK_BRANCH, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 0, 0, 0, 0));
		send(mk(rbc_pkg::AK_BRANCH, 3, 1, 0, 0, 0, 0, 0, 0, 0));
		// mispredicted branch, then a flush step that ignores its inputs
		send(mk(0, 0, 0, rbc_pkg::DK_BRANCH, 32'hCAFE_0000, 32'h0000_0001, 0, 0, 0, 0));
		send(mk(rbc_pkg::AK_BRANCH, 4, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(rbc_pkg::AK_VALUE, 0, 5, rbc_pkg::DK_REG, 7, 9, 1, 1, 0, 1));
		// branch ready with a wrong prediction bit
		send(mk(0, 0, 0, rbc_pkg::DK_BRANCH, 32'h8000_0000, 32'hFFFF_FFFE, 1, 0, 0, 0));
		send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// unused codes do nothing
		send(mk(2'd3, 0, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
			0, 0, 0));
		send(mk(0, 0, 0, 3'd5, 1, 1, 1, 0, 0, 0));
		// writeback to a free entry
		send(mk(rbc_pkg::AK_VALUE, 31, 32'h5555_5555, 0, 0, 0, 0, 1, 30, 32'hAAAA_AAAA));

		// random steps across idle phases and writeback rates
		for (int i = 0; i < 480; i++) begin
			if (i % 40 == 0) begin
				mode = (i / 40) % 4;
				send_idle_pct = mode == 1 ? 59 : mode == 3 ? 18 : 0;
				recv_stall_pct = mode == 2 ? 59 : mode == 3 ? 18 : 0;
				// starve writebacks now and then to fill the buffer
				wb_pct = (i / 40) % 3 == 1 ? 8 : (i / 40) % 3 == 2 ? 70 : 35;
			end
			send(rand_step());
		end

		// drain the buffer, then commit an exit
		settle();
		while (fill_level != 0) begin
			s = mk(0, 0, 0, 0, 0, 0, 0, 1, head_pos, $urandom);
			send(s);
			settle();
		end
		send(mk(0, 0, 0, rbc_pkg::DK_EXIT, 32'h0000_0011, 32'h8000_0001, 1, 0, 0, 0));
		// halted steps ignore all inputs
		repeat (3) send(rand_step());
		req_valid <= 1'b0;
		@(posedge clk);
		while (commits_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rbc_pkg.sv
rtl/rbc_ctrl.sv
rtl/rbc_datapath.sv
rtl/reorder_buffer_commit_unit.sv
rtl/rbc_checker.sv
tb/sv/rbc_checker.sv
tb/sv/tb_top.sv
